// ----- hw/rtl/sorted_table_binary_search_defines.svh -----
// assertion macros used by the checker file
`ifndef SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BINARY_SEARCH_DEFINES_SVH

// a stalled transfer keeps valid up and its payload unchanged
`define STBS_ASSERT_HOLD(lbl, vld, rdy, dat) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        ((vld) && !(rdy)) |=> ((vld) && $stable(dat))) \
        else $error("stalled transfer changed");

// plain implication checked at every edge out of reset
`define STBS_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> (cons)) \
        else $error("implication failed");

`endif

// ----- hw/rtl/stbs_pkg.sv -----
// shared constants and types of the sorted table search block
`default_nettype none

package stbs_pkg;

    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = 10;
    localparam int VALUE_W     = 32;
    // bounds carry one extra bit for the sign and one for headroom of low + high
    localparam int BOUND_W     = IDX_W + 2;
    localparam int IN_DATA_W   = 96;
    localparam int OUT_DATA_W  = 16;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    typedef enum logic
    {
        MODE_STORE  = 1'b0,
        MODE_SEARCH = 1'b1
    } mode_t;

    typedef struct packed
    {
        mode_t                     mode;
        logic [IDX_W-1:0]          entry_index;
        logic signed [VALUE_W-1:0] entry_value;
        logic [IDX_W-1:0]          low_bound;
        logic [IDX_W-1:0]          high_bound;
        logic signed [VALUE_W-1:0] search_key;
    } item_t;

    typedef struct packed
    {
        logic             found;
        logic [IDX_W-1:0] position;
    } result_t;

endpackage

`default_nettype wire

// ----- hw/rtl/sorted_table_binary_search.sv -----
// Binary search over a 1024-entry table of signed 32-bit values.
// Input stream s_axis: tuser is the mode (0 store, 1 search). A store writes
// entry_value at entry_index and gives no result; a search looks for
// search_key between low_bound and high_bound and gives one result.
// Output stream m_axis: tuser is the found flag, tdata the position
// (0 when the key is not found).
// Items enter a two-deep queue, so the input takes a transfer whenever the
// queue has room, even while a result waits at the output.
// A store uses the table port once. A search is issued from idle, which
// starts the first read, then makes one probe per cycle (up to 11 probes
// for 1024 entries, each a read of the single table port) and then, once
// the output register is free, loads the result into it.
// When the receiver stalls, the result holds in the output register, the
// next search finishes and waits, and the queue then fills and drops ready.
// Reset empties the queue and clears the output valid; table contents are
// undefined until written.
`default_nettype none

module sorted_table_binary_search
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entry_index, entry_value, low_bound, high_bound, search_key, zero pad
    input  wire  [stbs_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // mode
    input  wire                                  s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // position, zero pad
    output logic [stbs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // found
    output logic                                 m_axis_tuser
);
    import stbs_pkg::*;

    item_t q_item;
    logic  q_valid;
    logic  q_pop;

    stbs_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_item        (q_item),
        .q_valid       (q_valid),
        .q_pop         (q_pop)
    );

    stbs_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_item        (q_item),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// ----- hw/rtl/stbs_front.sv -----
// input side: takes transfers, splits the fields and queues the items
`default_nettype none

module stbs_front
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  s_axis_tvalid,
    output logic                                 s_axis_tready,
    // entry_index, entry_value, low_bound, high_bound, search_key, zero pad
    input  wire  [stbs_pkg::IN_DATA_W-1:0]       s_axis_tdata,
    // mode
    input  wire                                  s_axis_tuser,
    output stbs_pkg::item_t                      q_item,
    output logic                                 q_valid,
    input  wire                                  q_pop
);
    import stbs_pkg::*;

    item_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]  wr_ptr_reg;
    logic [QPTR_W-1:0]  rd_ptr_reg;
    logic [QPTR_W:0]    count_reg;
    item_t              in_item;
    logic               push;
    logic               pop;

    always_comb
    begin
        in_item.mode        = mode_t'(s_axis_tuser);
        in_item.entry_index = s_axis_tdata[9:0];
        in_item.entry_value = s_axis_tdata[41:10];
        in_item.low_bound   = s_axis_tdata[51:42];
        in_item.high_bound  = s_axis_tdata[61:52];
        in_item.search_key  = s_axis_tdata[93:62];
    end

    assign s_axis_tready = (count_reg != (QPTR_W+1)'(QUEUE_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (count_reg != '0);
    assign pop           = q_pop && q_valid;
    assign q_item        = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_item;
        end
    end

    // pointers wrap naturally since the queue depth is a power of two
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            unique case ({push, pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/stbs_back.sv -----
// execution side: table memory, probe sequencer and result register
`default_nettype none

module stbs_back
(
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  stbs_pkg::item_t                      q_item,
    input  wire                                  q_valid,
    output logic                                 q_pop,
    output logic                                 m_axis_tvalid,
    input  wire                                  m_axis_tready,
    // position, zero pad
    output logic [stbs_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
    // found
    output logic                                 m_axis_tuser
);
    import stbs_pkg::*;

    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_PROBE,
        ST_DRAIN
    } state_t;

    state_t                     state_reg;
    logic signed [BOUND_W-1:0]  lo_reg;
    logic signed [BOUND_W-1:0]  hi_reg;
    logic [IDX_W-1:0]           mid_reg;
    logic signed [VALUE_W-1:0]  key_reg;
    result_t                    res_reg;
    result_t                    out_reg;
    logic                       out_valid_reg;

    logic signed [VALUE_W-1:0]  mem [TABLE_DEPTH];
    logic signed [VALUE_W-1:0]  rdata_reg;

    logic                       is_search;
    logic                       probe_eq;
    logic                       key_lt;
    logic signed [BOUND_W-1:0]  mid_ext;
    logic signed [BOUND_W-1:0]  cand_lo;
    logic signed [BOUND_W-1:0]  cand_hi;
    logic signed [BOUND_W-1:0]  sum;
    logic [IDX_W-1:0]           mid_calc;
    logic                       empty;
    logic                       out_free;
    logic                       mem_we;
    logic                       mem_re;

    assign is_search = (q_item.mode == MODE_SEARCH);
    assign probe_eq  = (rdata_reg == key_reg);
    assign key_lt    = (key_reg < rdata_reg);
    assign mid_ext   = $signed({2'b00, mid_reg});

    // next range: fresh bounds when idle, narrowed range while probing
    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            cand_lo = $signed({2'b00, q_item.low_bound});
            cand_hi = $signed({2'b00, q_item.high_bound});
        end
        else if (key_lt)
        begin
            cand_lo = lo_reg;
            cand_hi = mid_ext - $signed(BOUND_W'(1));
        end
        else
        begin
            cand_lo = mid_ext + $signed(BOUND_W'(1));
            cand_hi = hi_reg;
        end
    end

    assign sum      = cand_lo + cand_hi;
    assign mid_calc = sum[IDX_W:1];
    assign empty    = (cand_lo > cand_hi);
    assign out_free = !out_valid_reg || m_axis_tready;

    assign q_pop  = (state_reg == ST_IDLE) && q_valid;
    assign mem_we = q_pop && !is_search;
    assign mem_re = (q_pop && is_search && !empty)
                 || ((state_reg == ST_PROBE) && !probe_eq && !empty);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[q_item.entry_index[ADDR_W-1:0]] <= q_item.entry_value;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mid_calc[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            lo_reg        <= '0;
            hi_reg        <= '0;
            mid_reg       <= '0;
            key_reg       <= '0;
            res_reg       <= '0;
            out_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (q_valid && is_search)
                    begin
                        lo_reg  <= cand_lo;
                        hi_reg  <= cand_hi;
                        mid_reg <= mid_calc;
                        key_reg <= q_item.search_key;
                        if (empty)
                        begin
                            res_reg   <= '0;
                            state_reg <= ST_DRAIN;
                        end
                        else
                        begin
                            state_reg <= ST_PROBE;
                        end
                    end
                end
                ST_PROBE:
                begin
                    if (probe_eq)
                    begin
                        res_reg.found    <= 1'b1;
                        res_reg.position <= mid_reg;
                        state_reg        <= ST_DRAIN;
                    end
                    else
                    begin
                        lo_reg  <= cand_lo;
                        hi_reg  <= cand_hi;
                        mid_reg <= mid_calc;
                        if (empty)
                        begin
                            res_reg   <= '0;
                            state_reg <= ST_DRAIN;
                        end
                    end
                end
                ST_DRAIN:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if ((state_reg == ST_DRAIN) && out_free)
            begin
                out_reg       <= res_reg;
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_DATA_W-IDX_W)'(0), out_reg.position};
    assign m_axis_tuser  = out_reg.found;

endmodule

`default_nettype wire

// ----- hw/rtl/stbs_checker.sv -----
// port-level checks on the sorted table search block
`default_nettype none
`include "sorted_table_binary_search_defines.svh"

module stbs_checker
(
    input wire                                   clk,
    input wire                                   rst_n,
    input wire                                   s_axis_tvalid,
    input wire                                   s_axis_tready,
    input wire                                   m_axis_tvalid,
    input wire                                   m_axis_tready,
    input wire [stbs_pkg::OUT_DATA_W-1:0]        m_axis_tdata,
    input wire                                   m_axis_tuser
);
    import stbs_pkg::*;

    // result held while the receiver stalls
    `STBS_ASSERT_HOLD(a_out_hold, m_axis_tvalid, m_axis_tready, {m_axis_tuser, m_axis_tdata})
    // a miss reports position zero
    `STBS_ASSERT_IMPL(a_miss_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == '0)
    // padding above the position stays zero
    `STBS_ASSERT_IMPL(a_pad_zero, m_axis_tvalid, m_axis_tdata[OUT_DATA_W-1:IDX_W] == '0)
    // the queue only fills up on an input transfer
    `STBS_ASSERT_IMPL(a_full_after_push, $fell(s_axis_tready), $past(s_axis_tvalid))

endmodule

bind sorted_table_binary_search stbs_checker u_stbs_checker (.*);

`default_nettype wire
